// ===== design/tvbc_pkg.sv =====
// Package for the TEA-variant block cipher: beat types, round constants
// and the per-stage round-sum function. No dependencies.
package tvbc_pkg;

  localparam int ROUNDS = 32;
  localparam int STAGES = 2 * ROUNDS;
  localparam int WORD_W = 32;
  localparam int KEYS = 4;
  localparam int KEY_IDX_W = $clog2(KEYS);
  localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEYS-1:0] key_t;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    word_t   y;
    word_t   z;
  } beat_t;

  // Constant control for one half-round stage.
  typedef struct packed {
    logic  odd;
    word_t sum_enc;
    word_t sum_dec;
  } stage_ctl_t;

  // Round sum n * delta, modulo 2^32.
  function automatic word_t round_sum(input int n);
    longint unsigned p;
    begin
      p = longint'(n) * longint'(DELTA);
      return p[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== design/tvbc_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on tvbc_pkg.
interface tvbc_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  tvbc_pkg::word_t     first_half;
  tvbc_pkg::word_t     second_half;

  modport source (output valid, action, first_half, second_half, input ready);
  modport sink   (input valid, action, first_half, second_half, output ready);
endinterface

interface tvbc_out_if;
  logic                valid;
  logic                ready;
  tvbc_pkg::word_t     out_first_half;
  tvbc_pkg::word_t     out_second_half;

  modport source (output valid, out_first_half, out_second_half, input ready);
  modport sink   (input valid, out_first_half, out_second_half, output ready);
endinterface

// ===== design/tvbc_round.sv =====
// One half-round pipeline stage: updates one half from the other and registers
// the beat. Depends on tvbc_pkg.
module tvbc_round (
  input  logic               clk,
  input  logic               rst_n,
  input  tvbc_pkg::stage_ctl_t ctl,
  input  tvbc_pkg::key_t     key,
  input  logic               up_valid,
  output logic               up_ready,
  input  tvbc_pkg::beat_t    up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output tvbc_pkg::beat_t    dn_data
);

  logic                        valid_r;
  tvbc_pkg::beat_t             data_r;
  tvbc_pkg::beat_t             data_nxt;
  logic                        dec;
  logic                        upd_z;
  tvbc_pkg::word_t             sum;
  logic [tvbc_pkg::KEY_IDX_W-1:0] kidx;
  tvbc_pkg::word_t             x;
  tvbc_pkg::word_t             t;
  tvbc_pkg::word_t             f;
  tvbc_pkg::word_t             t_new;

  always_comb begin
    dec   = (up_data.action == tvbc_pkg::ACT_DECRYPT);
    upd_z = dec ^ ctl.odd;
    sum   = dec ? ctl.sum_dec : ctl.sum_enc;
    kidx  = upd_z ? sum[12:11] : sum[1:0];
    x     = upd_z ? up_data.y : up_data.z;
    t     = upd_z ? up_data.z : up_data.y;
    f     = ((x << 4) ^ (x >> 5)) + (x ^ sum) + key[kidx];
    t_new = dec ? (t - f) : (t + f);
    data_nxt = up_data;
    if (upd_z) begin
      data_nxt.z = t_new;
    end else begin
      data_nxt.y = t_new;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/tea_variant_block_cipher.sv =====
// TEA-variant 64-bit block cipher, 128-bit key in four config words, 32 rounds.
// Each of the 64 pipeline stages does one half-round, and a new block (encrypt
// or decrypt, mixed freely) is accepted every cycle unless the pipeline is full
// and the output stalls. Each stage holds back only when its own register is
// full and the next cannot take it, so bubbles squeeze out under output stall.
// Key words must be written through cfg_* only while no block is in flight; the
// block does not enforce this. Depends on tvbc_pkg, tvbc_if and tvbc_round.
module tea_variant_block_cipher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [tvbc_pkg::KEY_IDX_W-1:0] cfg_index,
  input  tvbc_pkg::word_t     cfg_wdata,
  tvbc_in_if.sink             in_blk,
  tvbc_out_if.source          out_blk
);

  tvbc_pkg::key_t  key_r;
  logic            vld [tvbc_pkg::STAGES+1];
  logic            rdy [tvbc_pkg::STAGES+1];
  tvbc_pkg::beat_t dat [tvbc_pkg::STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign vld[0]        = in_blk.valid;
  assign in_blk.ready  = rdy[0];
  assign dat[0].action = tvbc_pkg::action_t'(in_blk.action);
  assign dat[0].y      = in_blk.first_half;
  assign dat[0].z      = in_blk.second_half;

  for (genvar s = 0; s < tvbc_pkg::STAGES; s++) begin : g_stage
    localparam int K = s / 2;
    localparam logic ODD = (s % 2) == 1;
    localparam int NE = ODD ? K + 1 : K;
    localparam int ND = ODD ? tvbc_pkg::ROUNDS - K - 1 : tvbc_pkg::ROUNDS - K;
    tvbc_pkg::stage_ctl_t ctl;

    assign ctl.odd     = ODD;
    assign ctl.sum_enc = tvbc_pkg::round_sum(NE);
    assign ctl.sum_dec = tvbc_pkg::round_sum(ND);

    tvbc_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .key      (key_r),
      .up_valid (vld[s]),
      .up_ready (rdy[s]),
      .up_data  (dat[s]),
      .dn_valid (vld[s+1]),
      .dn_ready (rdy[s+1]),
      .dn_data  (dat[s+1])
    );
  end

  assign out_blk.valid           = vld[tvbc_pkg::STAGES];
  assign rdy[tvbc_pkg::STAGES]   = out_blk.ready;
  assign out_blk.out_first_half  = dat[tvbc_pkg::STAGES].y;
  assign out_blk.out_second_half = dat[tvbc_pkg::STAGES].z;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_blk.valid && in_blk.ready |=> vld[1])
    else $error("accepted beat did not enter first stage");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_blk.ready |-> in_blk.ready)
    else $error("input stalled while output drains");

  a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> key_r[$past(cfg_index)] == $past(cfg_wdata))
    else $error("key word write lost");

  a_no_create: assert property (@(posedge clk) disable iff (!rst_n)
    !vld[tvbc_pkg::STAGES-1] && !(out_blk.valid && !out_blk.ready) |=> !out_blk.valid)
    else $error("result beat appeared from an empty stage");

endmodule
